// ===== hdl/log_header_check_window_bucket_assert.svh =====
// assertion macros shared by the block's rtl
`ifndef LOG_HEADER_CHECK_WINDOW_BUCKET_ASSERT_SVH
`define LOG_HEADER_CHECK_WINDOW_BUCKET_ASSERT_SVH

// same-cycle implication, off while reset is low
`define LHC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off while reset is low
`define LHC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/lhc_pkg.sv =====
package lhc_pkg;

    // header layout and limits
    localparam int unsigned HDR_LEN     = 16;
    localparam int unsigned COUNT_W     = 33;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam int unsigned STAMP_W     = 64;
    localparam int unsigned SIZE_W      = 32;
    localparam logic [STAMP_W-1:0] MIN_TS = 64'd1356998400000;

    localparam logic [7:0] VERSION_BYTE = 8'h01;
    localparam logic [7:0] MAGIC_0      = 8'hAB;
    localparam logic [7:0] MAGIC_1      = 8'hCD;
    localparam logic [7:0] MAGIC_2      = 8'hEF;

    // byte positions inside the header
    localparam logic [COUNT_W-1:0] POS_VERSION = 33'd0;
    localparam logic [COUNT_W-1:0] POS_MAGIC_0 = 33'd1;
    localparam logic [COUNT_W-1:0] POS_MAGIC_1 = 33'd2;
    localparam logic [COUNT_W-1:0] POS_MAGIC_2 = 33'd3;
    localparam logic [COUNT_W-1:0] POS_TS_LAST = 33'd11;
    localparam logic [COUNT_W-1:0] POS_SZ_LAST = 33'd15;

    // window register
    localparam int unsigned WIN_CFG_W     = 17;
    localparam int unsigned MS_PER_S      = 1000;
    localparam int unsigned WIN_W         = 27;
    localparam int unsigned WIN_CFG_RESET = 60;

    // queue between front and back
    localparam int unsigned QUEUE_DEPTH = 2;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_SHORT   = 3'd1,
        ST_VERSION = 3'd2,
        ST_MAGIC   = 3'd3,
        ST_OLD     = 3'd4,
        ST_SIZE    = 3'd5
    } t_status;

    typedef struct packed {
        t_status              status;
        logic [STAMP_W-1:0]   stamp;
    } t_entry;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_flags;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_FIN
    } t_back_state;

endpackage

// ===== hdl/lhc_queue.sv =====
module lhc_queue #(
    parameter int unsigned DEPTH = lhc_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  lhc_pkg::t_entry  i_entry,
    input  logic             i_pop,
    output lhc_pkg::t_entry  o_entry,
    output lhc_pkg::t_q_flags o_flags
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    lhc_pkg::t_entry  r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count,  n_count;

    // pointer wrap and fill count
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    assign o_entry       = r_mem[r_rd_ptr];
    assign o_flags.full  = (r_count == CNT_FULL);
    assign o_flags.empty = (r_count == '0);

endmodule

// ===== hdl/lhc_front.sv =====
module lhc_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [7:0]        i_data_byte,
    input  logic              i_last_byte,
    input  lhc_pkg::t_q_flags i_q_flags,
    output logic              o_push,
    output lhc_pkg::t_entry   o_entry
);

    logic [lhc_pkg::COUNT_W-1:0] r_count, n_count;
    logic [lhc_pkg::STAMP_W-1:0] r_time,  n_time;
    logic [lhc_pkg::SIZE_W-1:0]  r_size,  n_size;
    lhc_pkg::t_status            r_fault, n_fault;
    lhc_pkg::t_status            status;
    logic                        accept;
    logic [lhc_pkg::COUNT_W-1:0] expect_len;

    assign o_stall = i_q_flags.full;
    assign accept  = i_valid && !i_q_flags.full;

    // header field capture and checks for this word
    always_comb begin
        n_time  = r_time;
        n_size  = r_size;
        n_fault = r_fault;
        if (r_count == lhc_pkg::POS_VERSION) begin
            if (i_data_byte != lhc_pkg::VERSION_BYTE && r_fault == lhc_pkg::ST_OK) begin
                n_fault = lhc_pkg::ST_VERSION;
            end
        end else if (r_count == lhc_pkg::POS_MAGIC_0) begin
            if (i_data_byte != lhc_pkg::MAGIC_0 && r_fault == lhc_pkg::ST_OK) begin
                n_fault = lhc_pkg::ST_MAGIC;
            end
        end else if (r_count == lhc_pkg::POS_MAGIC_1) begin
            if (i_data_byte != lhc_pkg::MAGIC_1 && r_fault == lhc_pkg::ST_OK) begin
                n_fault = lhc_pkg::ST_MAGIC;
            end
        end else if (r_count == lhc_pkg::POS_MAGIC_2) begin
            if (i_data_byte != lhc_pkg::MAGIC_2 && r_fault == lhc_pkg::ST_OK) begin
                n_fault = lhc_pkg::ST_MAGIC;
            end
        end else if (r_count <= lhc_pkg::POS_TS_LAST) begin
            n_time = {r_time[lhc_pkg::STAMP_W-9:0], i_data_byte};
            if (r_count == lhc_pkg::POS_TS_LAST && n_time < lhc_pkg::MIN_TS
                    && r_fault == lhc_pkg::ST_OK) begin
                n_fault = lhc_pkg::ST_OLD;
            end
        end else if (r_count <= lhc_pkg::POS_SZ_LAST) begin
            n_size = {r_size[lhc_pkg::SIZE_W-9:0], i_data_byte};
        end
        n_count = (r_count == lhc_pkg::COUNT_MAX) ? r_count : r_count + 1'b1;
    end

    // classification at the end of a message
    assign expect_len = lhc_pkg::COUNT_W'(n_size) + lhc_pkg::COUNT_W'(lhc_pkg::HDR_LEN);

    always_comb begin
        if (n_count < lhc_pkg::COUNT_W'(lhc_pkg::HDR_LEN)) begin
            status = lhc_pkg::ST_SHORT;
        end else if (n_fault != lhc_pkg::ST_OK) begin
            status = n_fault;
        end else if (n_count != expect_len) begin
            status = lhc_pkg::ST_SIZE;
        end else begin
            status = lhc_pkg::ST_OK;
        end
    end

    assign o_push         = accept && i_last_byte;
    assign o_entry.status = status;
    assign o_entry.stamp  = n_time;

    // message state, cleared after the last word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_time  <= '0;
            r_size  <= '0;
            r_fault <= lhc_pkg::ST_OK;
        end else if (accept) begin
            if (i_last_byte) begin
                r_count <= '0;
                r_time  <= '0;
                r_size  <= '0;
                r_fault <= lhc_pkg::ST_OK;
            end else begin
                r_count <= n_count;
                r_time  <= n_time;
                r_size  <= n_size;
                r_fault <= n_fault;
            end
        end
    end

endmodule

// ===== hdl/lhc_back.sv =====
module lhc_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [lhc_pkg::WIN_CFG_W-1:0] i_cfg_wr_data,
    input  lhc_pkg::t_q_flags             i_q_flags,
    input  lhc_pkg::t_entry               i_entry,
    output logic                          o_pop,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [2:0]                    o_status,
    output logic [lhc_pkg::STAMP_W-1:0]   o_bucket_key
);

    localparam int unsigned WIN_W = lhc_pkg::WIN_W;
    localparam int unsigned BIT_W = $clog2(lhc_pkg::STAMP_W);
    localparam logic [WIN_W-1:0] WIN_RESET =
        WIN_W'(lhc_pkg::WIN_CFG_RESET * lhc_pkg::MS_PER_S);
    localparam logic [BIT_W-1:0] BIT_TOP = BIT_W'(lhc_pkg::STAMP_W - 1);

    lhc_pkg::t_back_state        r_state, n_state;
    logic [WIN_W-1:0]            r_win;
    logic [lhc_pkg::STAMP_W-1:0] r_stamp;
    logic [WIN_W-1:0]            r_rem, n_rem;
    logic [BIT_W-1:0]            r_bit;
    logic                        r_out_valid;
    lhc_pkg::t_status            r_out_status, n_out_status;
    logic [lhc_pkg::STAMP_W-1:0] r_out_key, n_out_key;
    logic                        out_free;
    logic                        load_out;
    logic                        start_div;
    logic [WIN_W:0]              trial;
    logic [WIN_W:0]              trial_sub;

    assign out_free = !r_out_valid || !i_stall;

    // one restoring remainder step per cycle, msb of the stamp first
    assign trial     = {r_rem, r_stamp[r_bit]};
    assign trial_sub = trial - {1'b0, r_win};
    assign n_rem     = (trial >= {1'b0, r_win}) ? trial_sub[WIN_W-1:0] : trial[WIN_W-1:0];

    // sequencer
    always_comb begin
        n_state      = r_state;
        o_pop        = 1'b0;
        load_out     = 1'b0;
        start_div    = 1'b0;
        n_out_status = lhc_pkg::ST_OK;
        n_out_key    = '0;
        case (r_state)
            lhc_pkg::BK_IDLE: begin
                if (!i_q_flags.empty && out_free) begin
                    o_pop = 1'b1;
                    if (i_entry.status == lhc_pkg::ST_OK && r_win != '0) begin
                        start_div = 1'b1;
                        n_state   = lhc_pkg::BK_DIV;
                    end else begin
                        load_out     = 1'b1;
                        n_out_status = i_entry.status;
                        n_out_key    = (i_entry.status == lhc_pkg::ST_OK) ?
                                       i_entry.stamp : '0;
                    end
                end
            end
            lhc_pkg::BK_DIV: begin
                if (r_bit == '0) begin
                    n_state = lhc_pkg::BK_FIN;
                end
            end
            lhc_pkg::BK_FIN: begin
                if (out_free) begin
                    load_out     = 1'b1;
                    n_out_status = lhc_pkg::ST_OK;
                    n_out_key    = r_stamp - lhc_pkg::STAMP_W'(r_rem);
                    n_state      = lhc_pkg::BK_IDLE;
                end
            end
            default: begin
                n_state = lhc_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lhc_pkg::BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // window length in ms
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= WIN_RESET;
        end else if (i_cfg_wr_en) begin
            r_win <= WIN_W'(i_cfg_wr_data) * WIN_W'(lhc_pkg::MS_PER_S);
        end
    end

    // divider datapath
    always_ff @(posedge i_clk) begin
        if (start_div) begin
            r_stamp <= i_entry.stamp;
            r_rem   <= '0;
            r_bit   <= BIT_TOP;
        end else if (r_state == lhc_pkg::BK_DIV) begin
            r_rem <= n_rem;
            r_bit <= r_bit - 1'b1;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_status <= n_out_status;
            r_out_key    <= n_out_key;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_status     = r_out_status;
    assign o_bucket_key = r_out_key;

endmodule

// ===== hdl/log_header_check_window_bucket.sv =====
// Log header checker with window bucketing.
// Input channel: one message byte per word (i_data_byte, i_last_byte on the final
// byte), taken when i_in_valid is high and o_in_stall is low; bytes flow at one per
// cycle while the result queue has room.
// Output channel: one word per message (o_status, o_bucket_key), taken when
// o_out_valid is high and i_out_stall is low; it holds while stalled.
// Config: i_cfg_wr_en writes window_seconds from i_cfg_wr_data; use it only while idle,
// which the block does not enforce. From the last byte, a rejected message or a zero
// window passes the result queue and the output register; an accepted one also
// waits on the bit-serial 64-step remainder unit, which takes no new message while
// it divides; short accepted messages fill the result queue and then raise o_in_stall.
// A stalled output holds its word; the back end then waits and the queue fills.
// Reset (i_rst_n low, synchronous) empties the queue, drops any partial message,
// clears the output valid and sets the window to 60 seconds.
`include "log_header_check_window_bucket_assert.svh"

module log_header_check_window_bucket #(
    parameter int unsigned QUEUE_DEPTH = lhc_pkg::QUEUE_DEPTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [7:0]                    i_data_byte,
    input  logic                          i_last_byte,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [2:0]                    o_status,
    output logic [lhc_pkg::STAMP_W-1:0]   o_bucket_key,
    input  logic                          i_cfg_wr_en,
    input  logic [lhc_pkg::WIN_CFG_W-1:0] i_cfg_wr_data
);

    logic              q_push;
    logic              q_pop;
    lhc_pkg::t_entry   q_in;
    lhc_pkg::t_entry   q_out;
    lhc_pkg::t_q_flags q_flags;

    // byte parser and header checks
    lhc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in_valid),
        .o_stall     (o_in_stall),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .i_q_flags   (q_flags),
        .o_push      (q_push),
        .o_entry     (q_in)
    );

    // classified messages waiting for the back end
    lhc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (q_in),
        .i_pop   (q_pop),
        .o_entry (q_out),
        .o_flags (q_flags)
    );

    // window rounding and output register
    lhc_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_q_flags     (q_flags),
        .i_entry       (q_out),
        .o_pop         (q_pop),
        .o_valid       (o_out_valid),
        .i_stall       (i_out_stall),
        .o_status      (o_status),
        .o_bucket_key  (o_bucket_key)
    );

    // checks
    `LHC_ASSERT_IMP(a_no_overflow, i_clk, i_rst_n, q_push, !q_flags.full, "push into full queue")
    `LHC_ASSERT_IMP(a_no_underflow, i_clk, i_rst_n, q_pop, !q_flags.empty, "pop from empty queue")
    `LHC_ASSERT_IMP(a_reject_key, i_clk, i_rst_n, o_out_valid && o_status != lhc_pkg::ST_OK, o_bucket_key == '0, "rejected word has nonzero key")
    `LHC_ASSERT_NXT(a_reject_fast, i_clk, i_rst_n, q_pop && q_out.status != lhc_pkg::ST_OK, o_out_valid && (o_status == $past(q_out.status)), "rejected entry not shown next cycle")

endmodule

// ===== verif/log_header_check_window_bucket_tb.sv =====
`timescale 1ns / 100ps

module log_header_check_window_bucket_tb;

    import lhc_pkg::*;

    // no-progress limit and settle time after the last result
    localparam int unsigned STALL_LIMIT   = 4000;
    localparam int unsigned SETTLE_CYCLES = 80;
    localparam logic [23:0] GOOD_MAGIC    = {MAGIC_0, MAGIC_1, MAGIC_2};

    typedef struct {
        t_status      status;
        logic [63:0]  key;
    } verdict_t;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_stall;
    logic [7:0]           i_data_byte;
    logic                 i_last_byte;
    logic                 o_out_valid;
    logic                 i_out_stall;
    logic [2:0]           o_status;
    logic [STAMP_W-1:0]   o_bucket_key;
    logic                 i_cfg_wr_en;
    logic [WIN_CFG_W-1:0] i_cfg_wr_data;

    // shadow of the header parser
    logic [WIN_CFG_W-1:0] window_sec;
    logic [COUNT_W-1:0]   msg_count;
    logic [STAMP_W-1:0]   stamp_acc;
    logic [SIZE_W-1:0]    size_acc;
    t_status              msg_fault;

    verdict_t             pending_verdicts[$];
    int unsigned          bytes_sent;
    int unsigned          mismatches;
    int unsigned          quiet_cycles;
    int unsigned          send_gap_pct;
    int unsigned          recv_stall_pct;

    log_header_check_window_bucket uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_data_byte   (i_data_byte),
        .i_last_byte   (i_last_byte),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_status      (o_status),
        .o_bucket_key  (o_bucket_key),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // keep only the earliest header fault
    function automatic void note_fault(input t_status code);
        if (msg_fault == ST_OK) msg_fault = code;
    endfunction

    // advance the shadow parser by one byte, returns 1 when a verdict is due
    function automatic logic absorb_byte(input logic [7:0] b, input logic last,
                                         output verdict_t v);
        logic [63:0] span;
        v.status = ST_OK;
        v.key    = '0;
        if (msg_count == POS_VERSION) begin
            if (b != VERSION_BYTE) note_fault(ST_VERSION);
        end else if (msg_count == POS_MAGIC_0) begin
            if (b != MAGIC_0) note_fault(ST_MAGIC);
        end else if (msg_count == POS_MAGIC_1) begin
            if (b != MAGIC_1) note_fault(ST_MAGIC);
        end else if (msg_count == POS_MAGIC_2) begin
            if (b != MAGIC_2) note_fault(ST_MAGIC);
        end else if (msg_count <= POS_TS_LAST) begin
            stamp_acc = {stamp_acc[55:0], b};
            if (msg_count == POS_TS_LAST && stamp_acc < MIN_TS) note_fault(ST_OLD);
        end else if (msg_count <= POS_SZ_LAST) begin
            size_acc = {size_acc[23:0], b};
        end
        if (msg_count != COUNT_MAX) msg_count = msg_count + 1'b1;
        if (!last) return 1'b0;

        if (msg_count < HDR_LEN) begin
            v.status = ST_SHORT;
        end else if (msg_fault != ST_OK) begin
            v.status = msg_fault;
        end else if (msg_count != {1'b0, size_acc} + 33'd16) begin
            v.status = ST_SIZE;
        end else begin
            span = 64'(window_sec) * 64'(MS_PER_S);
            v.key = (span == 64'd0) ? stamp_acc : stamp_acc - (stamp_acc % span);
        end
        msg_count = '0;
        stamp_acc = '0;
        size_acc  = '0;
        msg_fault = ST_OK;
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
        mismatches++;
    endtask

    // send one byte word, holding it until accepted
    task automatic send_byte(input logic [7:0] b, input logic last);
        verdict_t v;
        while ($urandom_range(99) < send_gap_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_data_byte <= b;
        i_last_byte <= last;
        do @(posedge i_clk); while (o_in_stall);
        bytes_sent++;
        if (absorb_byte(b, last, v)) pending_verdicts = {pending_verdicts, v};
    endtask

    // header fields followed by random payload, cut at len bytes
    task automatic send_message(input logic [7:0] ver, input logic [23:0] magic,
                                input logic [63:0] ts, input logic [31:0] size,
                                input int unsigned len);
        logic [7:0] b;
        for (int p = 0; p < len; p++) begin
            if (p == 0)       b = ver;
            else if (p < 4)   b = magic[23 - 8*(p-1) -: 8];
            else if (p < 12)  b = ts[63 - 8*(p-4) -: 8];
            else if (p < 16)  b = size[31 - 8*(p-12) -: 8];
            else              b = 8'($urandom_range(255));
            send_byte(b, p == len - 1);
        end
    endtask

    // write the window while the block is idle
    task automatic set_window(input logic [WIN_CFG_W-1:0] secs);
        i_in_valid <= 1'b0;
        while (pending_verdicts.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= secs;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        window_sec  = secs;
    endtask

    function automatic logic [63:0] pick_stamp();
        case ($urandom_range(3))
            0:       return MIN_TS;
            1:       return {$urandom, $urandom};
            default: return MIN_TS + {24'd0, 8'($urandom_range(255)), $urandom};
        endcase
    endfunction

    // each fault kind, fault priority and the stamp and size extremes
    task automatic test_header_faults();
        send_message(VERSION_BYTE, GOOD_MAGIC, MIN_TS, 32'd0, 16);
        send_message(VERSION_BYTE, GOOD_MAGIC, MIN_TS - 64'd1, 32'd0, 16);
        send_message(VERSION_BYTE, GOOD_MAGIC, '1, 32'd2, 18);
        send_message(8'h00, GOOD_MAGIC, MIN_TS, 32'd0, 16);
        send_message(8'hFF, 24'h000000, MIN_TS, 32'd0, 16);
        send_message(VERSION_BYTE, GOOD_MAGIC ^ 24'hFF0000, MIN_TS, 32'd0, 16);
        send_message(VERSION_BYTE, GOOD_MAGIC ^ 24'h00FF00, MIN_TS, 32'd0, 16);
        send_message(VERSION_BYTE, GOOD_MAGIC ^ 24'h000001, 64'd0, 32'd0, 16);
        send_message(VERSION_BYTE, GOOD_MAGIC, MIN_TS, 32'd0, 1);
        send_message(8'h00, GOOD_MAGIC, MIN_TS, 32'd0, 15);
        send_message(VERSION_BYTE, GOOD_MAGIC, MIN_TS, 32'hFFFF_FFFF, 16);
        send_message(VERSION_BYTE, GOOD_MAGIC, MIN_TS, 32'd1, 18);
        send_message(VERSION_BYTE, GOOD_MAGIC, 64'd12345, 32'd7, 16);
        send_message(VERSION_BYTE, GOOD_MAGIC, MIN_TS + 64'd59999, 32'd24, 40);
    endtask

    // zero window passes the stamp through unrounded
    task automatic test_zero_window();
        set_window('0);
        send_message(VERSION_BYTE, GOOD_MAGIC, MIN_TS + 64'd12345, 32'd0, 16);
        for (int k = 0; k < 3; k++)
            send_message(VERSION_BYTE, GOOD_MAGIC, pick_stamp(), 32'd1, 17);
    endtask

    // mostly well-formed messages, some broken ones and some noise
    task automatic run_random_traffic(input int unsigned byte_budget);
        int unsigned stop_at;
        int unsigned msgs;
        int unsigned roll;
        int unsigned plen;
        int unsigned len;
        logic [7:0]  ver;
        logic [23:0] magic;
        logic [63:0] ts;
        logic [31:0] size;
        stop_at = bytes_sent + byte_budget;
        msgs    = 0;
        while (bytes_sent < stop_at || msgs < 6) begin
            roll  = $urandom_range(99);
            plen  = ($urandom_range(19) == 0) ? $urandom_range(120, 13) : $urandom_range(12);
            ver   = VERSION_BYTE;
            magic = GOOD_MAGIC;
            ts    = pick_stamp();
            size  = plen;
            len   = HDR_LEN + plen;
            if (roll < 65) begin
                // well-formed
            end else if (roll < 72) begin
                if (roll[0]) size = $urandom;
                else         len  = len + $urandom_range(4, 1);
            end else if (roll < 78) begin
                ts = MIN_TS - 64'd1 - {32'd0, $urandom};
            end else if (roll < 84) begin
                ver = 8'($urandom_range(255));
                if (ver == VERSION_BYTE) ver = 8'h00;
            end else if (roll < 90) begin
                magic = magic ^ (24'(8'($urandom_range(255, 1))) << (8 * $urandom_range(2)));
            end else if (roll < 95) begin
                len = $urandom_range(15, 1);
            end else begin
                ver   = 8'($urandom_range(255));
                magic = 24'($urandom);
                ts    = {$urandom, $urandom};
                size  = $urandom;
                len   = $urandom_range(40, 1);
            end
            send_message(ver, magic, ts, size, len);
            msgs++;
        end
    endtask

    // result checker and receiver stall
    always @(posedge i_clk) begin : check_results
        verdict_t v;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_verdicts.size() == 0) begin
                report_mismatch("unexpected word, status", 64'(o_status), 64'd0);
            end else begin
                v = pending_verdicts.pop_front();
                if (o_status !== v.status)
                    report_mismatch("status", 64'(o_status), 64'(v.status));
                if (o_bucket_key !== v.key)
                    report_mismatch("bucket_key", o_bucket_key, v.key);
            end
        end
        i_out_stall <= i_rst_n && ($urandom_range(99) < recv_stall_pct);
    end

    // watchdog on cycles with no word moving
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("** log_header_check_window_bucket: FAILED **");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        i_rst_n        <= 1'b0;
        i_in_valid     <= 1'b0;
        i_data_byte    <= '0;
        i_last_byte    <= 1'b0;
        i_cfg_wr_en    <= 1'b0;
        i_cfg_wr_data  <= '0;
        window_sec     = WIN_CFG_RESET;
        msg_count      = '0;
        stamp_acc      = '0;
        size_acc       = '0;
        msg_fault      = ST_OK;
        bytes_sent     = 0;
        mismatches     = 0;
        send_gap_pct   = 13;
        recv_stall_pct = 75;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_header_faults();
        test_zero_window();
        set_window(17'd86400);
        run_random_traffic(250);

        send_gap_pct   = 75;
        recv_stall_pct = 13;
        set_window(17'd1);
        run_random_traffic(125);
        set_window('1);
        run_random_traffic(125);

        send_gap_pct   = 0;
        recv_stall_pct = 0;
        set_window(17'($urandom_range(86400, 1)));
        run_random_traffic(250);

        // drain and finish
        i_in_valid <= 1'b0;
        while (pending_verdicts.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && pending_verdicts.size() == 0) begin
            $display("** log_header_check_window_bucket: PASSED **");
        end else begin
            $display("** log_header_check_window_bucket: FAILED **");
        end
        $finish;
    end

endmodule
